/* rtl/h2r_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the HSV to RGB converter pipeline.
// No dependencies; every other file imports this package.
package h2r_pkg;

  localparam int unsigned SectorDeg = 60;
  localparam int unsigned FullDeg   = 360;
  localparam int unsigned UnitScale = 15300;  // 255 * 60

  // floor(n / 15300) == ((n >> 2) * RecipMul) >> RecipShift for n < 2^22
  localparam int unsigned RecipShift = 32;
  localparam logic [20:0] RecipMul   = 21'd1122868;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // after sector split
  typedef struct packed {
    sector_t     sector;
    logic [5:0]  span;   // weight subtracted for the secondary channel
    logic [7:0]  sat;
    logic [7:0]  val;
  } s1_t;

  // after the first products
  typedef struct packed {
    sector_t     sector;
    logic [5:0]  span;
    logic [15:0] vs;
    logic [21:0] base;
    logic [7:0]  val;
  } s2_t;

  // channel numerators
  typedef struct packed {
    sector_t     sector;
    logic [21:0] lo_num;
    logic [21:0] x_num;
    logic [7:0]  val;
  } s3_t;

  // channel levels before sector routing
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  lo;
    logic [7:0]  x;
    logic [7:0]  val;
  } s4_t;

endpackage

/* rtl/hsv_to_rgb_converter.sv */
`timescale 1ns / 1ps
// Top level of the HSV to RGB converter: stage chain and sector routing to R, G, B.
// Depends on h2r_pkg, h2r_sector, h2r_product and h2r_divide.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------
//   input   | in_valid, in_stall | hue[8:0] saturation brightness
//   output  | out_valid,out_stall| red green blue (8 bits each)
//
// One pixel per clock while the output is not stalled, through five register stages
// (sector split, products, numerators, reciprocal divide, channel routing).
// Synchronous reset clears all stage valid bits; payload registers are not reset.
// A stall on the output holds every full stage; empty stages still fill, so
// bubbles close up while the output waits.
module hsv_to_rgb_converter import h2r_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [8:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic in_ready;
  logic s1_valid, s1_ready;
  logic s3_valid, s3_ready;
  logic s4_valid, s4_ready;
  s1_t  s1;
  s3_t  s3;
  s4_t  s4;
  logic [7:0] red_next, green_next, blue_next;

  assign in_stall = !in_ready;

  h2r_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hue       (hue),
    .sat       (saturation),
    .val       (brightness),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1)
  );

  h2r_product u_product (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3)
  );

  h2r_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3),
    .out_valid (s4_valid),
    .out_ready (s4_ready),
    .out_data  (s4)
  );

  // route peak level (val), secondary (x) and floor (lo) by sector
  always_comb begin
    case (s4.sector)
      SEC_RY: begin
        red_next = s4.val; green_next = s4.x; blue_next = s4.lo;
      end
      SEC_YG: begin
        red_next = s4.x; green_next = s4.val; blue_next = s4.lo;
      end
      SEC_GC: begin
        red_next = s4.lo; green_next = s4.val; blue_next = s4.x;
      end
      SEC_CB: begin
        red_next = s4.lo; green_next = s4.x; blue_next = s4.val;
      end
      SEC_BM: begin
        red_next = s4.x; green_next = s4.lo; blue_next = s4.val;
      end
      default: begin
        red_next = s4.val; green_next = s4.lo; blue_next = s4.x;
      end
    endcase
  end

  assign s4_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_ready) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid && s4_ready) begin
      red <= red_next;
      green <= green_next;
      blue <= blue_next;
    end
  end

endmodule

/* rtl/h2r_sector.sv */
`timescale 1ns / 1ps
// First pipeline stage: hue wrap, sector and in-sector offset.
// Depends on h2r_pkg.
module h2r_sector import h2r_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] hue,
  input  logic [7:0] sat,
  input  logic [7:0] val,
  output logic       out_valid,
  input  logic       out_ready,
  output s1_t        out_data
);

  logic [8:0] hue_w;
  logic [8:0] sec_base;
  logic [8:0] rem_full;
  logic [5:0] rem;
  sector_t    sector;
  s1_t        data_next;

  always_comb begin
    hue_w = (hue >= 9'(FullDeg)) ? hue - 9'(FullDeg) : hue;
    if (hue_w < 9'(SectorDeg)) begin
      sector = SEC_RY;
      sec_base = 9'd0;
    end else if (hue_w < 9'(2 * SectorDeg)) begin
      sector = SEC_YG;
      sec_base = 9'(SectorDeg);
    end else if (hue_w < 9'(3 * SectorDeg)) begin
      sector = SEC_GC;
      sec_base = 9'(2 * SectorDeg);
    end else if (hue_w < 9'(4 * SectorDeg)) begin
      sector = SEC_CB;
      sec_base = 9'(3 * SectorDeg);
    end else if (hue_w < 9'(5 * SectorDeg)) begin
      sector = SEC_BM;
      sec_base = 9'(4 * SectorDeg);
    end else begin
      sector = SEC_MR;
      sec_base = 9'(5 * SectorDeg);
    end
    rem_full = hue_w - sec_base;
    rem = rem_full[5:0];
    data_next.sector = sector;
    // rising edge in even sectors, falling in odd ones
    data_next.span = sector[0] ? rem : 6'(SectorDeg) - rem;
    data_next.sat = sat;
    data_next.val = val;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/h2r_product.sv */
`timescale 1ns / 1ps
// Second and third pipeline stages: v*s and v*15300, then the channel numerators.
// Depends on h2r_pkg.
module h2r_product import h2r_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s3_t  out_data
);

  logic mid_valid;
  logic mid_ready;
  s2_t  mid;
  s2_t  mid_next;
  s3_t  data_next;
  logic [21:0] vs_chroma;
  logic [21:0] vs_span;

  always_comb begin
    mid_next.sector = in_data.sector;
    mid_next.span = in_data.span;
    mid_next.vs = 16'(in_data.val) * 16'(in_data.sat);
    mid_next.base = 22'(in_data.val) * 22'(UnitScale);
    mid_next.val = in_data.val;
  end

  assign in_ready = !mid_valid || mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mid <= mid_next;
    end
  end

  // base never falls below either product, since vs <= 255 * val
  always_comb begin
    vs_chroma = 22'(mid.vs) * 22'(SectorDeg);
    vs_span = 22'(mid.vs) * 22'(mid.span);
    data_next.sector = mid.sector;
    data_next.lo_num = mid.base - vs_chroma;
    data_next.x_num = mid.base - vs_span;
    data_next.val = mid.val;
  end

  assign mid_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* rtl/h2r_divide.sv */
`timescale 1ns / 1ps
// Fourth pipeline stage: divide both numerators by 15300 through a reciprocal product.
// Depends on h2r_pkg.
module h2r_divide import h2r_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s3_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s4_t  out_data
);

  logic [40:0] prod_lo;
  logic [40:0] prod_x;
  s4_t         data_next;

  // drop the factor of four first, then multiply by the reciprocal of 3825
  always_comb begin
    prod_lo = 41'(in_data.lo_num[21:2]) * 41'(RecipMul);
    prod_x = 41'(in_data.x_num[21:2]) * 41'(RecipMul);
    data_next.sector = in_data.sector;
    data_next.lo = prod_lo[RecipShift +: 8];
    data_next.x = prod_x[RecipShift +: 8];
    data_next.val = in_data.val;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

/* tb/hsv_to_rgb_converter_chk.sv */
`timescale 1ns / 1ps
// Checker for the HSV to RGB converter: watches both channels, predicts each pixel
// and compares it with the result that leaves the block. Depends on h2r_pkg.
module hsv_to_rgb_converter_chk import h2r_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [8:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output int unsigned pixels_due,
  output int unsigned fail_count
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t rgb_due[$];

  function automatic rgb_t hsv_to_rgb(logic [8:0] h, logic [7:0] s, logic [7:0] v);
    int unsigned deg, rem, sat, val, vs, chroma, side, offset;
    int unsigned r_part, g_part, b_part;
    sector_t     sec;
    rgb_t        px;
    deg = 32'(h);
    sat = 32'(s);
    val = 32'(v);
    // hue past a full turn folds back once
    if (deg >= FullDeg) begin
      deg = deg - FullDeg;
    end
    sec    = sector_t'(3'(deg / SectorDeg));
    rem    = deg % SectorDeg;
    vs     = val * sat;
    chroma = vs * SectorDeg;
    side   = sec[0] ? vs * (SectorDeg - rem) : vs * rem;
    offset = val * UnitScale - chroma;
    case (sec)
      SEC_RY: begin r_part = chroma; g_part = side;   b_part = 0;      end
      SEC_YG: begin r_part = side;   g_part = chroma; b_part = 0;      end
      SEC_GC: begin r_part = 0;      g_part = chroma; b_part = side;   end
      SEC_CB: begin r_part = 0;      g_part = side;   b_part = chroma; end
      SEC_BM: begin r_part = side;   g_part = 0;      b_part = chroma; end
      default: begin r_part = chroma; g_part = 0;     b_part = side;   end
    endcase
    px.red   = 8'((r_part + offset) / UnitScale);
    px.green = 8'((g_part + offset) / UnitScale);
    px.blue  = 8'((b_part + offset) / UnitScale);
    return px;
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      rgb_due.delete();
      pixels_due <= 0;
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rgb_due.size() == 0) begin
          $display("%0t: unexpected pixel red=%0d green=%0d blue=%0d",
                   $time, red, green, blue);
          fail_count <= fail_count + 1;
        end else begin
          want = rgb_due.pop_front();
          if (red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, red);
          end
          if (green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, green);
          end
          if (blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, blue);
          end
          if ({red, green, blue} !== want) begin
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        rgb_due.push_back(hsv_to_rgb(hue, saturation, brightness));
      end
      pixels_due <= rgb_due.size();
    end
  end

endmodule

/* tb/hsv_to_rgb_converter_tb.sv */
`timescale 1ns / 1ps
// Top of the HSV to RGB converter bench: clock, reset, pixel stimulus, output
// back-pressure and the verdict. Depends on h2r_pkg, the DUT and its checker.
module hsv_to_rgb_converter_tb;
  import h2r_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [8:0]  hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  int unsigned pixels_due;
  int unsigned fail_count;
  bit          gaps_on;

  hsv_to_rgb_converter dut (.*);
  hsv_to_rgb_converter_chk chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400us;
    $display("hsv_to_rgb_converter: mismatch");
    $finish;
  end

  // offer one pixel and hold it until the transfer happens
  task automatic send_pixel(input logic [8:0] h, input logic [7:0] s, input logic [7:0] v);
    bit taken;
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off, then a stretch that never stalls
  initial begin
    int unsigned cyc;
    int unsigned hold_left;
    cyc = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 150) begin
        hold_left = 60;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (cyc >= 500 && cyc < 800) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 31);
      end
    end
  end

  initial begin
    logic [8:0] h;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    hue        <= '0;
    saturation <= '0;
    brightness <= '0;
    gaps_on     = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sector edges at full colour, hue wrap, grey, black and a few mid tones
    send_pixel(9'd0,   8'd255, 8'd255);
    send_pixel(9'd59,  8'd255, 8'd255);
    send_pixel(9'd60,  8'd255, 8'd255);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd255);
    send_pixel(9'd179, 8'd255, 8'd255);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd239, 8'd255, 8'd255);
    send_pixel(9'd240, 8'd255, 8'd255);
    send_pixel(9'd299, 8'd255, 8'd255);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd359, 8'd255, 8'd255);
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd419, 8'd200, 8'd180);
    send_pixel(9'd479, 8'd128, 8'd255);
    send_pixel(9'd511, 8'd255, 8'd255);
    send_pixel(9'd90,  8'd0,   8'd255);
    send_pixel(9'd200, 8'd255, 8'd0);
    send_pixel(9'd0,   8'd0,   8'd0);
    send_pixel(9'd200, 8'd128, 8'd77);
    send_pixel(9'd30,  8'd1,   8'd1);
    send_pixel(9'd7,   8'd170, 8'd85);
    send_pixel(9'd333, 8'd254, 8'd254);

    for (int i = 0; i < 700; i++) begin
      // back-to-back transfers for a while
      gaps_on = !(i >= 350 && i < 500);
      if ($urandom_range(99) < 15) begin
        h = 9'($urandom_range(511, 360));
      end else begin
        h = 9'($urandom_range(359));
      end
      send_pixel(h, pick_level(), pick_level());
    end
    in_valid <= 1'b0;

    // let the checker count the last transfer before polling the backlog
    @(posedge clk);
    while (pixels_due != 0) begin
      @(posedge clk);
    end
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("hsv_to_rgb_converter: match");
    end else begin
      $display("hsv_to_rgb_converter: mismatch");
    end
    $finish;
  end

endmodule
